[hdl/lss_pkg.sv]
// lss_pkg: shared types and constants for the lifo stack with search
// no dependencies; imported by the channel interfaces and all modules

package lss_pkg;

    // width of one stored word
    localparam int DATA_W = 32;

    // request operation codes
    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_LIST   = 2'd2,
        FUNC_SEARCH = 2'd3
    } func_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

[hdl/lss_if.sv]
// lss_if: valid/ready channel interfaces for requests and results
// depends on lss_pkg for the data width

interface lss_req_if;
    import lss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               func;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output func, output data_value, input ready);
    modport sink   (input valid, input func, input data_value, output ready);
endinterface

interface lss_rsp_if;
    import lss_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic [1:0]               status;
    logic                     found;
    logic                     last;

    modport source (output valid, output out_value, output status, output found,
                    output last, input ready);
    modport sink   (input valid, input out_value, input status, input found,
                    input last, output ready);
endinterface

[hdl/lifo_stack_with_search.sv]
// lifo_stack_with_search: stack controller, scan sequencer and result register
// depends on lss_pkg, lss_if (lss_req_if, lss_rsp_if) and lss_mem
//
//  channel  dir   payload                          handshake
//  req      in    func, data_value                 valid / ready
//  rsp      out   out_value, status, found, last   valid / ready
//
// one request at a time; req.ready is high only while the controller is idle
// push and pop are accepted, then finish with the memory write or read-data result
// list emits every entry from the top down; search scans from the top down to a hit
// or the base entry; on an empty stack either gives one status result; the scan is paced
// by the single read port of the store, one entry per cycle, a list only while rsp is free
// a result register decouples rsp: a new request is taken while a result waits,
// and the controller stalls in place only when it must emit into a full register
// reset empties the stack at once; no clearing pass is needed

module lifo_stack_with_search #(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    lss_req_if.sink    req,
    lss_rsp_if.source  rsp
);
    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PUSH = 4'b0010,
        ST_POP  = 4'b0100,
        ST_SCAN = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [1:0]               func_reg;
    logic signed [DATA_W-1:0] val_reg;

    logic                     req_accept;
    logic                     out_free;
    logic [CW-1:0]            count_dec;
    logic                     is_full;
    logic                     is_empty;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    logic                     emit;
    logic signed [DATA_W-1:0] emit_value;
    status_t                  emit_status;
    logic                     emit_found;
    logic                     emit_last;
    logic                     hit;

    logic                     rsp_valid_reg;
    logic signed [DATA_W-1:0] rsp_value_reg;
    logic [1:0]               rsp_status_reg;
    logic                     rsp_found_reg;
    logic                     rsp_last_reg;

    // stack store
    lss_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (val_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // handshake helpers
    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && (state_reg == ST_IDLE);
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign count_dec  = count_reg - 1'b1;
    assign is_full    = (count_reg == CW'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign wr_addr    = count_reg[AW-1:0];
    assign hit        = (rd_data == val_reg);

    // controller and scan sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = count_dec[AW-1:0];
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = STATUS_OK;
        emit_found  = 1'b0;
        emit_last   = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    unique case (req.func)
                        FUNC_PUSH:
                        begin
                            state_next = ST_PUSH;
                        end
                        FUNC_POP:
                        begin
                            rd_en      = !is_empty;
                            state_next = ST_POP;
                        end
                        default:
                        begin
                            // list and search start at the top entry
                            rd_en      = !is_empty;
                            ptr_next   = count_dec[AW-1:0];
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end

            ST_PUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (is_full)
                    begin
                        emit_status = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_POP:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (is_empty)
                    begin
                        emit_status = STATUS_EMPTY;
                    end
                    else
                    begin
                        emit_value = rd_data;
                        count_next = count_dec;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (is_empty)
                begin
                    // empty list reports empty, empty search reports not found
                    if (out_free)
                    begin
                        emit = 1'b1;
                        if (func_reg == FUNC_LIST)
                        begin
                            emit_status = STATUS_EMPTY;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else if (func_reg == FUNC_LIST)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_value = rd_data;
                        emit_last  = (ptr_reg == '0);
                        if (ptr_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = ptr_reg - 1'b1;
                            ptr_next = ptr_reg - 1'b1;
                        end
                    end
                end
                else
                begin
                    if (hit || (ptr_reg == '0))
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            emit_found = hit;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg - 1'b1;
                        ptr_next = ptr_reg - 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            func_reg <= req.func;
            val_reg  <= req.data_value;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_value_reg  <= emit_value;
            rsp_status_reg <= emit_status;
            rsp_found_reg  <= emit_found;
            rsp_last_reg   <= emit_last;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.out_value = rsp_value_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.found     = rsp_found_reg;
    assign rsp.last      = rsp_last_reg;

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // scan pointer stays inside the filled part of the store
    a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && count_reg != '0) |-> (CW'(ptr_reg) < count_reg))
        else $error("scan pointer outside filled entries");

    // a stored push grows the stack by one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && emit && !is_full)
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the stack");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!rsp_valid_reg || rsp.ready))
        else $error("result register overwritten");

endmodule

[hdl/lss_mem.sv]
// lss_mem: stack word store, one write port and one registered read port
// depends on lss_pkg for the data width

module lss_mem #(
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [$clog2(DEPTH)-1:0]               wr_addr,
    input  logic signed [lss_pkg::DATA_W-1:0]      wr_data,
    input  logic                                   rd_en,
    input  logic [$clog2(DEPTH)-1:0]               rd_addr,
    output logic signed [lss_pkg::DATA_W-1:0]      rd_data
);
    import lss_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[bench/lss_checker.sv]
`timescale 1ns / 1ps
// lss_checker: watches the request and result channels of the lifo stack,
// keeps its own copy of the stack and compares every result in order
// depends on lss_pkg and lss_if (lss_req_if, lss_rsp_if)

module lss_checker #(
    parameter int DEPTH = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    lss_req_if    req,
    lss_rsp_if    rsp,
    output int    n_fail,
    output int    n_pending
);
    import lss_pkg::*;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_value;
        status_t                  status;
        logic                     found;
        logic                     last;
    } rsp_item_t;

    logic signed [DATA_W-1:0] stack_mem [DEPTH];
    int                       fill_count;
    rsp_item_t                pending_rsp [$];
    int                       mismatch_count;

    // apply one request to the stack copy and queue the results it causes
    task automatic track_request(input func_t op, input logic signed [DATA_W-1:0] val);
        rsp_item_t r;
        int        i;
        r = '0;
        r.status = STATUS_OK;
        r.last = 1'b1;
        case (op)
            FUNC_PUSH:
            begin
                if (fill_count >= DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    stack_mem[fill_count] = val;
                    fill_count++;
                end
                pending_rsp.push_back(r);
            end
            FUNC_POP:
            begin
                if (fill_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    fill_count--;
                    r.out_value = stack_mem[fill_count];
                end
                pending_rsp.push_back(r);
            end
            FUNC_LIST:
            begin
                if (fill_count == 0)
                begin
                    r.status = STATUS_EMPTY;
                    pending_rsp.push_back(r);
                end
                else
                begin
                    // top entry first, last flag only on the base entry
                    for (i = fill_count - 1; i >= 0; i--)
                    begin
                        r.out_value = stack_mem[i];
                        r.last = (i == 0);
                        pending_rsp.push_back(r);
                    end
                end
            end
            default:
            begin
                // search scans top to base, stack left as is
                for (i = fill_count - 1; i >= 0; i--)
                begin
                    if (stack_mem[i] == val)
                    begin
                        r.found = 1'b1;
                    end
                end
                pending_rsp.push_back(r);
            end
        endcase
    endtask

    // compare one accepted result against the oldest expectation
    task automatic check_rsp();
        rsp_item_t exp_r;
        if (pending_rsp.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%0t: unexpected result: value=%h status=%0d found=%0b last=%0b",
                         $realtime, rsp.out_value, rsp.status, rsp.found, rsp.last);
            end
        end
        else
        begin
            exp_r = pending_rsp.pop_front();
            if (rsp.out_value !== exp_r.out_value || rsp.status !== exp_r.status ||
                rsp.found !== exp_r.found || rsp.last !== exp_r.last)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("%0t: result mismatch: expected value=%h status=%0d found=%0b last=%0b",
                             $realtime, exp_r.out_value, exp_r.status, exp_r.found, exp_r.last);
                    $display("%0t:                  actual   value=%h status=%0d found=%0b last=%0b",
                             $realtime, rsp.out_value, rsp.status, rsp.found, rsp.last);
                end
            end
        end
    endtask

    // results are checked before the request of the same edge is tracked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count = 0;
            pending_rsp.delete();
            mismatch_count = 0;
            n_fail <= 0;
            n_pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                check_rsp();
            end
            if (req.valid && req.ready)
            begin
                track_request(func_t'(req.func), req.data_value);
            end
            n_fail <= mismatch_count;
            n_pending <= pending_rsp.size();
        end
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// tb: stimulus, result-side stalls, watchdog and verdict for the lifo stack
// depends on lss_pkg, lss_if, lifo_stack_with_search and lss_checker

module tb;
    import lss_pkg::*;

    localparam int DEPTH      = 64;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_LIMIT = 5000;

    logic clk;
    logic rst_n;
    logic hold_kick;

    int n_fail;
    int n_pending;
    int idle_cycles;
    int burst_left;
    int hist_idx;

    logic signed [DATA_W-1:0] pushed_hist [16];

    lss_req_if req_ch ();
    lss_rsp_if rsp_ch ();

    lifo_stack_with_search #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lss_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: random stall modes, plus a long hold-off on request
    initial
    begin : rsp_sink
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_kick)
            begin
                hold_left = HOLD_LEN;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 128);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("** lifo_stack_with_search: FAILED **");
        $finish;
    end

    // offer one request and wait until it is taken; bursts with random gaps
    task automatic send_request(input func_t op, input logic signed [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.func <= op;
        req_ch.data_value <= val;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        if (op == FUNC_PUSH)
        begin
            pushed_hist[hist_idx] = val;
            hist_idx = (hist_idx + 1) % 16;
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (n_pending != 0);
    endtask

    // values biased toward extremes and a small set that repeats
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        else if (sel < 40)
        begin
            return $signed(32'($urandom_range(0, 15))) - 32'sd8;
        end
        return $signed($urandom());
    endfunction

    // search keys: half from values pushed lately, half arbitrary
    function automatic logic signed [DATA_W-1:0] pick_key();
        if ($urandom_range(0, 1) == 1)
        begin
            return pushed_hist[$urandom_range(0, 15)];
        end
        return pick_value();
    endfunction

    // weighted mix of all four operations
    task automatic send_mixed(input int n, input int push_pct, input int pop_pct);
        int r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
            begin
                send_request(FUNC_PUSH, pick_value());
            end
            else if (r < push_pct + pop_pct)
            begin
                send_request(FUNC_POP, pick_value());
            end
            else if (r < push_pct + pop_pct + 10)
            begin
                send_request(FUNC_LIST, pick_value());
            end
            else
            begin
                send_request(FUNC_SEARCH, pick_key());
            end
        end
    endtask

    initial
    begin : stimulus
        int i;
        rst_n <= 1'b0;
        hold_kick <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_PUSH;
        req_ch.data_value <= '0;
        burst_left = 0;
        hist_idx = 0;
        for (i = 0; i < 16; i++)
        begin
            pushed_hist[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack: pop, list and search
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_LIST, 32'sd0);
        send_request(FUNC_SEARCH, 32'sd0);
        // extremes, then searches hitting top, middle, base and a miss
        send_request(FUNC_PUSH, 32'sh7fff_ffff);
        send_request(FUNC_PUSH, 32'sh8000_0000);
        send_request(FUNC_PUSH, 32'sh0);
        send_request(FUNC_PUSH, -32'sd1);
        send_request(FUNC_SEARCH, 32'sh8000_0000);
        send_request(FUNC_SEARCH, 32'sh7fff_ffff);
        send_request(FUNC_SEARCH, 32'sd5);
        send_request(FUNC_SEARCH, -32'sd1);
        send_request(FUNC_LIST, 32'sd0);
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_LIST, 32'sd0);
        send_request(FUNC_SEARCH, -32'sd1);
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_PUSH, 32'sh5555_5555);
        send_request(FUNC_PUSH, 32'shaaaa_aaaa);
        send_request(FUNC_LIST, 32'sd0);
        send_request(FUNC_POP, 32'sd0);
        send_request(FUNC_POP, 32'sd0);

        // fill past full so some pushes are dropped
        repeat (DEPTH + 6)
        begin
            send_request(FUNC_PUSH, pick_value());
        end
        // long result-side hold while full list and searches keep coming
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        send_request(FUNC_LIST, pick_value());
        repeat (10)
        begin
            send_request(FUNC_SEARCH, pick_key());
        end
        drain();

        // random mix around the middle of the stack
        send_mixed(30, 35, 30);
        drain();
        // drain to empty and keep popping
        repeat (DEPTH + 6)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_request(FUNC_SEARCH, pick_key());
            end
            else
            begin
                send_request(FUNC_POP, pick_value());
            end
        end
        send_mixed(20, 40, 25);

        drain();
        repeat (20) @(posedge clk);
        if (n_fail == 0 && n_pending == 0)
        begin
            $display("** lifo_stack_with_search: PASSED **");
        end
        else
        begin
            $display("** lifo_stack_with_search: FAILED **");
        end
        $finish;
    end

endmodule

[files.f]
hdl/lss_pkg.sv
hdl/lss_if.sv
hdl/lss_mem.sv
hdl/lifo_stack_with_search.sv
bench/lss_checker.sv
bench/tb.sv
